// File: src/pcx_pkg.sv
// Shared types and constants for the PCX run-length palette decoder.
// No dependencies; used by pcx_ctrl, pcx_datapath and the top level.
package pcx_pkg;

    // palette
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

    // run-length byte coding
    localparam logic [7:0] RUN_HDR_MASK = 8'hC0;
    localparam logic [5:0] RUN_CNT_MASK = 6'h3F;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCAN_LINE_BYTES = 2'd0,
        CFG_IMAGE_WIDTH     = 2'd1,
        CFG_IMAGE_HEIGHT    = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] RST_SCAN_LINE_BYTES = 16'd320;
    localparam logic [15:0] RST_IMAGE_WIDTH     = 16'd320;
    localparam logic [15:0] RST_IMAGE_HEIGHT    = 16'd200;

    // controller -> datapath
    typedef struct packed {
        logic pal_wr;      // write palette entry from input word
        logic hold_hdr;    // latch run count from header byte
        logic start_lit;   // start a one-pixel run
        logic start_held;  // start a run of the latched count
        logic step;        // advance one column
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_hdr;      // current data byte is a run header
        logic held_zero;   // latched run count is zero
        logic out_free;    // output register can take a pixel
        logic run_done;    // this step ends the run
    } t_dp_status;

endpackage

// File: src/pcx_ctrl.sv
// Controller FSM for the PCX decoder: input handshake, run sequencing.
// Depends on pcx_pkg.
module pcx_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_pal,
    input  pcx_pkg::t_dp_status    i_status,
    output logic                   o_in_ready,
    output pcx_pkg::t_ctrl_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_await, n_await;
    logic   accept;
    logic   data_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready & i_in_valid;
    assign data_acc   = accept & ~i_in_pal;

    always_comb begin
        n_state = r_state;
        n_await = r_await;
        o_cmd   = '0;
        o_cmd.pal_wr = accept & i_in_pal;
        unique case (r_state)
            S_IDLE: begin
                if (data_acc) begin
                    if (r_await) begin
                        // value byte of a run
                        o_cmd.start_held = 1'b1;
                        n_await          = 1'b0;
                        if (!i_status.held_zero) begin
                            n_state = S_RUN;
                        end
                    end else if (i_status.is_hdr) begin
                        o_cmd.hold_hdr = 1'b1;
                        n_await        = 1'b1;
                    end else begin
                        o_cmd.start_lit = 1'b1;
                        n_state         = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.run_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_await <= 1'b0;
        end else begin
            r_state <= n_state;
            r_await <= n_await;
        end
    end

endmodule

// File: src/pcx_datapath.sv
// Datapath for the PCX decoder: config registers, run counter, column/row
// counters, palette memory and output register. Depends on pcx_pkg.
module pcx_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config writes
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // input word fields
    input  logic [7:0]           i_data_byte,
    input  logic [7:0]           i_palette_index,
    input  logic [7:0]           i_pal_red,
    input  logic [7:0]           i_pal_green,
    input  logic [7:0]           i_pal_blue,
    // control
    input  pcx_pkg::t_ctrl_cmd   i_cmd,
    output pcx_pkg::t_dp_status  o_status,
    // output word
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_pixel_red,
    output logic [7:0]           o_pixel_green,
    output logic [7:0]           o_pixel_blue,
    output logic [15:0]          o_pixel_column,
    output logic [15:0]          o_pixel_row,
    output logic                 o_last_of_run,
    output logic                 o_end_of_frame
);

    logic [15:0] r_slb, r_width, r_height;
    logic [5:0]  r_held, r_cnt;
    logic [15:0] r_pos, r_row;
    logic [23:0] r_rgb;
    logic        r_rd_ok;

    logic        r_ovalid;
    logic [23:0] r_orgb;
    logic [15:0] r_ocol, r_orow;
    logic        r_olast, r_oeof;

    logic [23:0] mem [pcx_pkg::PAL_DEPTH];

    logic [15:0] len, hgt, lastcol;
    logic [16:0] pos1, row1;
    logic        emit, line_end, last, eof, cnt_one, start, wr_ok, rd_ok;

    // zero length or height behaves as one
    assign len     = (r_slb == 16'd0) ? 16'd1 : r_slb;
    assign hgt     = (r_height == 16'd0) ? 16'd1 : r_height;
    assign lastcol = (r_width < len) ? r_width : len;

    assign pos1     = {1'b0, r_pos} + 17'd1;
    assign row1     = {1'b0, r_row} + 17'd1;
    assign cnt_one  = (r_cnt == 6'd1);
    assign emit     = (r_pos < r_width);
    assign line_end = (pos1 >= {1'b0, len});
    // no later pixel of this run lands inside the visible width
    assign last     = cnt_one || (pos1 >= {1'b0, r_width}) || line_end;
    assign eof      = (row1 == {1'b0, hgt}) && (pos1 == {1'b0, lastcol});
    assign start    = i_cmd.start_lit | i_cmd.start_held;

    assign wr_ok = ({24'd0, i_palette_index} < 32'(pcx_pkg::PAL_DEPTH));
    assign rd_ok = ({24'd0, i_data_byte} < 32'(pcx_pkg::PAL_DEPTH));

    assign o_status.is_hdr    = ((i_data_byte & pcx_pkg::RUN_HDR_MASK)
                                 == pcx_pkg::RUN_HDR_MASK);
    assign o_status.held_zero = (r_held == 6'd0);
    assign o_status.out_free  = ~r_ovalid | i_out_ready;
    assign o_status.run_done  = cnt_one | line_end;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slb    <= pcx_pkg::RST_SCAN_LINE_BYTES;
            r_width  <= pcx_pkg::RST_IMAGE_WIDTH;
            r_height <= pcx_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcx_pkg::CFG_SCAN_LINE_BYTES: r_slb    <= i_cfg_data;
                pcx_pkg::CFG_IMAGE_WIDTH:     r_width  <= i_cfg_data;
                pcx_pkg::CFG_IMAGE_HEIGHT:    r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // run count and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 6'd0;
            r_cnt  <= 6'd0;
            r_pos  <= 16'd0;
            r_row  <= 16'd0;
        end else begin
            if (i_cmd.hold_hdr) begin
                r_held <= i_data_byte[5:0] & pcx_pkg::RUN_CNT_MASK;
            end
            if (i_cmd.start_lit) begin
                r_cnt <= 6'd1;
            end else if (i_cmd.start_held) begin
                r_cnt <= r_held;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt - 6'd1;
            end
            if (i_cmd.step) begin
                if (line_end) begin
                    r_pos <= 16'd0;
                    r_row <= (row1 >= {1'b0, hgt}) ? 16'd0 : row1[15:0];
                end else begin
                    r_pos <= pos1[15:0];
                end
            end
        end
    end

    // palette memory; read once per run, address is the run value
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr && wr_ok) begin
            mem[i_palette_index[pcx_pkg::PAL_AW-1:0]] <= {i_pal_red, i_pal_green, i_pal_blue};
        end
        if (start) begin
            r_rgb   <= mem[i_data_byte[pcx_pkg::PAL_AW-1:0]];
            r_rd_ok <= rd_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.step && emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && emit) begin
            r_orgb  <= r_rd_ok ? r_rgb : 24'd0;
            r_ocol  <= r_pos;
            r_orow  <= r_row;
            r_olast <= last;
            r_oeof  <= eof;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_pixel_red    = r_orgb[23:16];
    assign o_pixel_green  = r_orgb[15:8];
    assign o_pixel_blue   = r_orgb[7:0];
    assign o_pixel_column = r_ocol;
    assign o_pixel_row    = r_orow;
    assign o_last_of_run  = r_olast;
    assign o_end_of_frame = r_oeof;

endmodule

// File: src/pcx_rle_palette_decoder_top.sv
// Top level of the PCX run-length palette decoder.
// Depends on pcx_pkg, pcx_ctrl and pcx_datapath.
//
// Channel   Dir  Signals                    Word
// s_axis    in   tvalid/tready/tdata/tuser  one byte or one palette write
// m_axis    out  tvalid/tready/tdata/tlast/tuser  one RGB pixel
// cfg       in   valid/ready/index/data     one register write
//
// Palette writes and run headers make no column step; a literal byte makes
// one once accepted, a run value min(count, columns left in the line). The
// single column counter steps once per cycle unless stalled. Reset:
// synchronous active low; config returns to 320/320/200, counters to 0. The
// palette is not cleared. Stalls: a full output register holds the column
// step; s_axis is only ready between runs. cfg is always ready.
module pcx_rle_palette_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] data_byte, [15:8] palette_index, [23:16] pal_red,
    // [31:24] pal_green, [39:32] pal_blue
    input  logic [39:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,   // [0] cmd: 0 data byte, 1 palette write
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue,
    // [39:24] pixel_column, [55:40] pixel_row
    output logic [55:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,   // last_of_run
    output logic        o_m_axis_tuser,   // [0] end_of_frame
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    pcx_pkg::t_ctrl_cmd  s_cmd;
    pcx_pkg::t_dp_status s_status;

    logic [7:0]  s_red, s_green, s_blue;
    logic [15:0] s_col, s_row;

    assign o_cfg_ready = 1'b1;

    pcx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_pal   (i_s_axis_tuser),
        .i_status   (s_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (s_cmd)
    );

    pcx_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_s_axis_tdata[7:0]),
        .i_palette_index (i_s_axis_tdata[15:8]),
        .i_pal_red       (i_s_axis_tdata[23:16]),
        .i_pal_green     (i_s_axis_tdata[31:24]),
        .i_pal_blue      (i_s_axis_tdata[39:32]),
        .i_cmd           (s_cmd),
        .o_status        (s_status),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_pixel_red     (s_red),
        .o_pixel_green   (s_green),
        .o_pixel_blue    (s_blue),
        .o_pixel_column  (s_col),
        .o_pixel_row     (s_row),
        .o_last_of_run   (o_m_axis_tlast),
        .o_end_of_frame  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {s_row, s_col, s_blue, s_green, s_red};

`ifndef SYNTHESIS
    // at most one input-side command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.pal_wr, s_cmd.hold_hdr, s_cmd.start_lit, s_cmd.start_held}))
        else $error("pcx: conflicting input commands");

    // column steps only happen while input is blocked
    a_step_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.step |-> !o_s_axis_tready)
        else $error("pcx: column step while input ready");

    // a literal always enters the run state
    a_lit_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.start_lit |=> !o_s_axis_tready)
        else $error("pcx: literal did not start a run");

    // a step that must stall never advances
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !s_cmd.step)
        else $error("pcx: step into a full output register");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for pcx_rle_palette_decoder_top.
// Needs pcx_pkg and the decoder RTL; predicts every pixel and checks each output word.
module tb_top;

    // Idle cycles before a register write once the pixel queue is empty: a run
    // through padding columns keeps stepping for up to 63 columns with no output.
    localparam int DRAIN_CYCLES   = 80;
    // Cycles with no word moving on any channel before the run is abandoned.
    // The longest legal quiet stretch is the long output hold-off below.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 25;

    // Expected pixel, laid out as {tuser, tlast, tdata} of the output stream.
    typedef struct packed {
        logic        eof;
        logic        last;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pixel;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [39:0] s_data    = '0;
    logic        s_user    = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_data;
    logic        m_last;
    logic        m_user;
    logic        cfg_ready;

    pcx_rle_palette_decoder_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder mirror: geometry registers, run state, position, palette
    // ------------------------------------------------------------------
    logic [15:0] line_len   = pcx_pkg::RST_SCAN_LINE_BYTES;
    logic [15:0] img_width  = pcx_pkg::RST_IMAGE_WIDTH;
    logic [15:0] img_height = pcx_pkg::RST_IMAGE_HEIGHT;
    logic        run_pending = 1'b0;
    logic [5:0]  run_count   = '0;
    logic [15:0] col_pos     = '0;
    logic [15:0] row_pos     = '0;
    logic [23:0] pal_mem [pcx_pkg::PAL_DEPTH];

    t_pixel expected_pixels [$];

    // bookkeeping
    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  pixels_checked = 0;
    int  geometries     = 0;
    int  stall_cycles   = 0;
    int  rx_wait        = 0;
    int  rx_hold        = 0;
    bit  burst_mode     = 1'b0;   // no random idle gaps on either side while set

    // Work out the pixels that one accepted input word produces.
    task automatic decode_word(input logic cmd, input logic [39:0] word);
        t_pixel run_buf [64];
        t_pixel pix;
        logic [7:0] value;
        logic [7:0] idx;
        logic [23:0] rgb;
        int count, n, len, height, lastcol, i;
        n = 0;
        if (cmd) begin
            idx = word[15:8];
            if (int'(idx) < pcx_pkg::PAL_DEPTH)
                pal_mem[idx] = {word[23:16], word[31:24], word[39:32]};
            return;
        end
        value = word[7:0];
        if (run_pending) begin
            count       = int'(run_count);
            run_pending = 1'b0;
        end else if ((value & pcx_pkg::RUN_HDR_MASK) == pcx_pkg::RUN_HDR_MASK) begin
            run_pending = 1'b1;
            run_count   = value[5:0] & pcx_pkg::RUN_CNT_MASK;
            return;
        end else begin
            count = 1;
        end
        len     = (line_len == 16'd0) ? 1 : int'(line_len);
        height  = (img_height == 16'd0) ? 1 : int'(img_height);
        lastcol = (int'(img_width) < len) ? int'(img_width) : len;
        rgb     = (int'(value) < pcx_pkg::PAL_DEPTH) ? pal_mem[value] : 24'h0;
        for (i = 0; i < count; i++) begin
            if (col_pos < img_width) begin
                pix.red   = rgb[23:16];
                pix.green = rgb[15:8];
                pix.blue  = rgb[7:0];
                pix.col   = col_pos;
                pix.row   = row_pos;
                pix.last  = 1'b0;
                pix.eof   = (int'(row_pos) + 1 == height) &&
                            (int'(col_pos) + 1 == lastcol);
                run_buf[n] = pix;
                n++;
            end
            col_pos = col_pos + 16'd1;
            if (int'(col_pos) >= len || col_pos == 16'd0) begin
                col_pos = '0;
                row_pos = row_pos + 16'd1;
                if (int'(row_pos) >= height)
                    row_pos = '0;
                break;
            end
        end
        for (i = 0; i < n; i++) begin
            pix = run_buf[i];
            if (i == n - 1)
                pix.last = 1'b1;
            expected_pixels.push_back(pix);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: one word per call, random gap before it
    // ------------------------------------------------------------------
    task automatic send_word(input logic cmd, input logic [39:0] word);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        s_user  <= cmd;
        do @(posedge clk); while (!s_ready);
        words_sent++;
        decode_word(cmd, word);
    endtask

    // Data byte; the palette fields carry noise the block must ignore.
    task automatic send_data(input logic [7:0] data_val);
        logic [31:0] noise;
        noise = $urandom;
        send_word(1'b0, {noise, data_val});
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [7:0] red,
                                input logic [7:0] green, input logic [7:0] blue);
        logic [7:0] noise;
        noise = 8'($urandom_range(0, 255));
        send_word(1'b1, {blue, green, red, idx, noise});
    endtask

    task automatic send_run(input logic [5:0] count, input logic [7:0] value);
        send_data(pcx_pkg::RUN_HDR_MASK | {2'b00, count});
        send_data(value);
    endtask

    // Mostly well-formed runs and literals, palette writes as noise in between,
    // sometimes inside a run pair. Pixel values stay on loaded palette entries.
    task automatic send_random_item();
        int pick;
        logic [5:0] count;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 6));
            send_data(pcx_pkg::RUN_HDR_MASK | {2'b00, count});
            if ($urandom_range(0, 9) == 0)
                send_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            send_data({6'($urandom_range(0, 63)), 2'b00});
        end else if (pick < 85) begin
            // multiples of four up to 0xBC: never a run header
            send_data({6'($urandom_range(0, 47)), 2'b00});
        end else begin
            send_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Geometry change: only with the block idle and every pixel delivered.
    task automatic set_geometry(input logic [15:0] line, input logic [15:0] width,
                                input logic [15:0] height);
        pcx_pkg::t_cfg_idx id;
        logic [15:0]       val;
        int k;
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (k = 0; k < 3; k++) begin
            case (k)
                0:       begin id = pcx_pkg::CFG_SCAN_LINE_BYTES; val = line;   end
                1:       begin id = pcx_pkg::CFG_IMAGE_WIDTH;     val = width;  end
                default: begin id = pcx_pkg::CFG_IMAGE_HEIGHT;    val = height; end
            endcase
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= id;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            case (id)
                pcx_pkg::CFG_SCAN_LINE_BYTES: line_len   = val;
                pcx_pkg::CFG_IMAGE_WIDTH:     img_width  = val;
                default:                      img_height = val;
            endcase
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        geometries++;
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and pixel checker
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_wait != 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    t_pixel got_pix;
    t_pixel want_pix;

    always @(posedge clk) begin
        if (rst_n && m_valid && m_tready) begin
            got_pix = {m_user, m_last, m_data};
            rx_wait = burst_mode ? 0 : $urandom_range(0, 7);
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: pixel with none expected: ",
                              "rgb %h%h%h col %0d row %0d l%b e%b"},
                             $realtime, got_pix.red, got_pix.green, got_pix.blue,
                             got_pix.col, got_pix.row, got_pix.last, got_pix.eof);
            end else begin
                want_pix = expected_pixels.pop_front();
                pixels_checked++;
                if (got_pix.red !== want_pix.red || got_pix.green !== want_pix.green ||
                    got_pix.blue !== want_pix.blue || got_pix.col !== want_pix.col ||
                    got_pix.row !== want_pix.row || got_pix.last !== want_pix.last ||
                    got_pix.eof !== want_pix.eof) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"%0t: pixel mismatch, expected ",
                                  "rgb %h%h%h col %0d row %0d l%b e%b"},
                                 $realtime, want_pix.red, want_pix.green,
                                 want_pix.blue, want_pix.col, want_pix.row,
                                 want_pix.last, want_pix.eof);
                        $display({"%0t:                 actual   ",
                                  "rgb %h%h%h col %0d row %0d l%b e%b"},
                                 $realtime, got_pix.red, got_pix.green,
                                 got_pix.blue, got_pix.col, got_pix.row,
                                 got_pix.last, got_pix.eof);
                    end
                end
            end
        end
    end

    // Watchdog: no word on any channel for too long means the block is stuck.
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d quiet cycles, %0d pixels still expected",
                         stall_cycles, expected_pixels.size());
                $display("FAIL pcx_rle_palette_decoder_top");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load every fourth palette entry plus 0xBF and 0xFF; all pixel values
    // used below come from this set. Entry 0 is black and entry 0xFF white.
    task automatic test_palette_load();
        int i;
        for (i = 0; i < 64; i++) begin
            if (i == 0)
                send_palette(8'h00, 8'h00, 8'h00, 8'h00);
            else
                send_palette(8'(i * 4), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        send_palette(8'hBF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        send_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_directed();
        // reset geometry: literals land at row 0 from column 0
        send_data(8'h00);
        send_data(8'hBF);
        send_run(6'd3, 8'hFF);
        // small frame so rows wrap and end of frame shows up
        set_geometry(16'd8, 16'd6, 16'd2);
        send_data(8'h04);
        send_run(6'd3, 8'hFF);
        send_run(6'd0, 8'h10);                 // empty run, value byte swallowed
        send_data(pcx_pkg::RUN_HDR_MASK | 8'h02);  // palette write between header and value
        send_palette(8'h20, 8'h5A, 8'hA5, 8'h3C);
        send_data(8'h20);
        send_run(6'h3F, 8'h0C);                // clipped at the line end
        send_run(6'd7, 8'h80);                 // runs into the padding columns
        send_run(6'h3F, 8'h40);
        // width beyond the line: last decoded byte is the last visible pixel
        set_geometry(16'd4, 16'd9, 16'd1);
        send_run(6'd9, 8'hA8);
        send_data(8'h54);
        // zero width: nothing visible
        set_geometry(16'd3, 16'd0, 16'd0);
        send_data(8'h14);
        send_run(6'd5, 8'h24);
        // zero line length and height behave as one
        set_geometry(16'd0, 16'd2, 16'd0);
        send_data(8'h34);
        send_data(8'h44);
    endtask

    task automatic test_random_phases();
        logic [15:0] line, width, height;
        int phase, start;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       begin line = 16'd8;     width = 16'd6;     height = 16'd3;     end
                1:       begin line = 16'd1;     width = 16'd1;     height = 16'd1;     end
                2:       begin line = 16'hFFFF;  width = 16'hFFFF;  height = 16'hFFFF;  end
                3:       begin line = 16'd5;     width = 16'd9;     height = 16'd2;     end
                4:       begin line = 16'd16;    width = 16'd16;    height = 16'd1;     end
                5:       begin line = 16'd12;    width = 16'd7;     height = 16'd4;     end
                6:       begin line = 16'd3;     width = 16'd2;     height = 16'hFFFF;  end
                default: begin line = 16'd0;     width = 16'd3;     height = 16'd0;     end
            endcase
            // geometry shrinks under a live position now and then: no reset between
            set_geometry(line, width, height);
            burst_mode = (phase % 3 == 0);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
                send_random_item();
            burst_mode = 1'b0;
        end
    endtask

    // Output held off for a long stretch while the input keeps offering words.
    task automatic test_output_stall();
        int start;
        set_geometry(16'd10, 16'd8, 16'd3);
        burst_mode = 1'b1;
        rx_hold    = HOLD_CYCLES;
        start      = words_sent;
        while (words_sent - start < 30)
            send_random_item();
        burst_mode = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_palette_load();
        test_directed();
        test_random_phases();
        test_output_stall();

        // drain: every expected pixel, then quiet cycles for strays
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            mismatch_count++;

        $display("Sent %0d input words over %0d geometry settings; checked %0d pixels.",
                 words_sent, geometries, pixels_checked);
        $display({"Runs, literals, palette writes, clipping, padding and an ",
                  "output stall; %0d mismatches."}, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS pcx_rle_palette_decoder_top");
        else
            $display("FAIL pcx_rle_palette_decoder_top");
        $finish;
    end

endmodule

// File: sim.f
src/pcx_pkg.sv
src/pcx_ctrl.sv
src/pcx_datapath.sv
src/pcx_rle_palette_decoder_top.sv
test/tb_top.sv
